>>> rtl/core/rrw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rrw_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int X_W        = 32;                 // residual width
    localparam int MAGX_W     = X_W;                // |x| up to 2^31
    localparam int SIGMA_W    = 31;
    localparam int K_W        = 24;
    localparam int W_W        = FRAC_BITS + 1;      // weight width
    localparam int DIV1_STEPS = MAGX_W + 1;         // quotient bits below the overflow check
    localparam int DIV2_STEPS = W_W;                // quotient bits of the weight divide
    localparam int DIV2_N_W   = MAGX_W + FRAC_BITS; // widest dividend of the weight divide

    typedef enum logic {
        MODE_HUBER    = 1'b0,
        MODE_BISQUARE = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        REG_MODE  = 2'd0,
        REG_K     = 2'd1,
        REG_SIGMA = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic             valid;
        t_mode            mode;
        logic             sat;
        logic [K_W-1:0]   k;
    } t_ctl;

endpackage
`default_nettype wire

>>> rtl/core/rrw_scale_div.sv
`timescale 1ns / 1ps
`default_nettype none
module rrw_scale_div
    import rrw_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  wire t_ctl               i_ctl,
    input  wire logic               i_neg,
    input  wire logic [MAGX_W-1:0]  i_mag_x,
    input  wire logic [SIGMA_W-1:0] i_sigma,
    output t_ctl                    o_ctl,
    output logic [MAGX_W-1:0]       o_mag_u
);
    localparam int NUM_W = DIV1_STEPS;

    t_ctl                 r_ctl   [0:DIV1_STEPS];
    logic                 r_neg   [0:DIV1_STEPS];
    logic                 r_ovf   [0:DIV1_STEPS];
    logic [SIGMA_W-1:0]   r_sig   [0:DIV1_STEPS];
    logic [MAGX_W-1:0]    r_rem   [0:DIV1_STEPS];
    logic [NUM_W-1:0]     r_num   [0:DIV1_STEPS];
    logic [NUM_W-1:0]     r_q     [0:DIV1_STEPS];
    t_ctl                 r_octl;
    logic [MAGX_W-1:0]    r_mag_u;

    logic [MAGX_W-1:0]    n_limit;
    logic                 n_sat;
    t_ctl                 n_octl;

    // Entry: top dividend bits decide overflow past the quotient width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0].valid <= 1'b0;
        end else if (i_adv) begin
            r_ctl[0] <= i_ctl;
        end
        if (i_adv) begin
            r_neg[0] <= i_neg;
            r_sig[0] <= i_sigma;
            r_ovf[0] <= {{(SIGMA_W-(MAGX_W-FRAC_BITS-1)){1'b0}},
                         i_mag_x[MAGX_W-1:NUM_W-FRAC_BITS]} >= i_sigma;
            r_rem[0] <= {{(FRAC_BITS+1){1'b0}}, i_mag_x[MAGX_W-1:NUM_W-FRAC_BITS]};
            r_num[0] <= {i_mag_x[NUM_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
            r_q[0]   <= '0;
        end
    end

    for (genvar g = 0; g < DIV1_STEPS; g++) begin : g_step
        logic [MAGX_W-1:0] n_t;
        logic              n_ge;
        assign n_t  = {r_rem[g][MAGX_W-2:0], r_num[g][NUM_W-1]};
        assign n_ge = n_t >= {1'b0, r_sig[g]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[g+1].valid <= 1'b0;
            end else if (i_adv) begin
                r_ctl[g+1] <= r_ctl[g];
            end
            if (i_adv) begin
                r_neg[g+1] <= r_neg[g];
                r_ovf[g+1] <= r_ovf[g];
                r_sig[g+1] <= r_sig[g];
                r_rem[g+1] <= n_ge ? n_t - {1'b0, r_sig[g]} : n_t;
                r_num[g+1] <= {r_num[g][NUM_W-2:0], 1'b0};
                r_q[g+1]   <= {r_q[g][NUM_W-2:0], n_ge};
            end
        end
    end

    // Clip to the signed Q16.16 magnitude range
    always_comb begin
        n_limit = r_neg[DIV1_STEPS] ? {1'b1, {(MAGX_W-1){1'b0}}} : {1'b0, {(MAGX_W-1){1'b1}}};
        n_sat   = r_ovf[DIV1_STEPS] || (r_q[DIV1_STEPS] > {1'b0, n_limit});
        n_octl     = r_ctl[DIV1_STEPS];
        n_octl.sat = n_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octl.valid <= 1'b0;
        end else if (i_adv) begin
            r_octl <= n_octl;
        end
        if (i_adv) begin
            r_mag_u <= n_sat ? n_limit : r_q[DIV1_STEPS][MAGX_W-1:0];
        end
    end

    assign o_ctl   = r_octl;
    assign o_mag_u = r_mag_u;
endmodule
`default_nettype wire

>>> rtl/core/rrw_weight_div.sv
`timescale 1ns / 1ps
`default_nettype none
module rrw_weight_div
    import rrw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire t_ctl              i_ctl,
    input  wire logic [MAGX_W-1:0] i_mag_u,
    output t_ctl                   o_ctl,
    output logic                   o_inside,
    output logic [W_W-1:0]         o_q
);
    t_ctl                 r_ctl [0:DIV2_STEPS];
    logic                 r_in  [0:DIV2_STEPS];
    logic [MAGX_W-1:0]    r_d   [0:DIV2_STEPS];
    logic [MAGX_W:0]      r_rem [0:DIV2_STEPS];
    logic [W_W-1:0]       r_num [0:DIV2_STEPS];
    logic [W_W-1:0]       r_q   [0:DIV2_STEPS];

    logic [DIV2_N_W-1:0]  n_n;
    logic [MAGX_W-1:0]    n_d;
    logic [MAGX_W-1:0]    n_k;

    // Huber: (k << F) / |u|; bisquare: (|u| << F) / k. Quotient fits W_W bits when used.
    always_comb begin
        n_k = {{(MAGX_W-K_W){1'b0}}, i_ctl.k};
        if (i_ctl.mode == MODE_BISQUARE) begin
            n_n = {i_mag_u, {FRAC_BITS{1'b0}}};
            n_d = n_k;
        end else begin
            n_n = {n_k, {FRAC_BITS{1'b0}}};
            n_d = i_mag_u;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0].valid <= 1'b0;
        end else if (i_adv) begin
            r_ctl[0] <= i_ctl;
        end
        if (i_adv) begin
            r_in[0]  <= i_mag_u <= n_k;
            r_d[0]   <= n_d;
            r_rem[0] <= {2'b00, n_n[DIV2_N_W-1:W_W]};
            r_num[0] <= n_n[W_W-1:0];
            r_q[0]   <= '0;
        end
    end

    for (genvar g = 0; g < DIV2_STEPS; g++) begin : g_step
        logic [MAGX_W:0] n_t;
        logic            n_ge;
        assign n_t  = {r_rem[g][MAGX_W-1:0], r_num[g][W_W-1]};
        assign n_ge = n_t >= {1'b0, r_d[g]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[g+1].valid <= 1'b0;
            end else if (i_adv) begin
                r_ctl[g+1] <= r_ctl[g];
            end
            if (i_adv) begin
                r_in[g+1]  <= r_in[g];
                r_d[g+1]   <= r_d[g];
                r_rem[g+1] <= n_ge ? n_t - {1'b0, r_d[g]} : n_t;
                r_num[g+1] <= {r_num[g][W_W-2:0], 1'b0};
                r_q[g+1]   <= {r_q[g][W_W-2:0], n_ge};
            end
        end
    end

    assign o_ctl    = r_ctl[DIV2_STEPS];
    assign o_inside = r_in[DIV2_STEPS];
    assign o_q      = r_q[DIV2_STEPS];
endmodule
`default_nettype wire

>>> rtl/core/rrw_shape.sv
`timescale 1ns / 1ps
`default_nettype none
module rrw_shape
    import rrw_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_adv,
    input  wire t_ctl           i_ctl,
    input  wire logic           i_inside,
    input  wire logic [W_W-1:0] i_q,
    output t_ctl                o_ctl,
    output logic [W_W-1:0]      o_weight
);
    localparam logic [W_W-1:0] ONE_FX = W_W'(1) << FRAC_BITS;

    t_ctl                 r_ctl1, r_ctl2, r_ctl3;
    logic                 r_in1, r_in2;
    logic [W_W-1:0]       r_q1, r_q2;
    logic [2*W_W-1:0]     r_aa;
    logic [2*W_W-1:0]     r_bb;
    logic [W_W-1:0]       r_w;
    logic [W_W-1:0]       n_b;

    assign n_b = ONE_FX - r_aa[FRAC_BITS+W_W-1:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1.valid <= 1'b0;
            r_ctl2.valid <= 1'b0;
            r_ctl3.valid <= 1'b0;
        end else if (i_adv) begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
        end
        if (i_adv) begin
            r_in1 <= i_inside;
            r_q1  <= i_q;
            r_aa  <= i_q * i_q;
            r_in2 <= r_in1;
            r_q2  <= r_q1;
            r_bb  <= n_b * n_b;
            if (r_ctl2.mode == MODE_BISQUARE) begin
                r_w <= r_in2 ? r_bb[FRAC_BITS+W_W-1:FRAC_BITS] : '0;
            end else begin
                r_w <= r_in2 ? ONE_FX : r_q2;
            end
        end
    end

    assign o_ctl    = r_ctl3;
    assign o_weight = r_w;
endmodule
`default_nettype wire

>>> rtl/core/robust_regression_weight.sv
`timescale 1ns / 1ps
`default_nettype none
// Huber / Tukey bisquare robust weight: each signed Q16.16 residual is scaled by sigma,
// clipped to the Q16.16 range (tuser flags a clip) and mapped to an unsigned Q1.16
// weight. Fully pipelined: one transaction per cycle through two bit-per-stage
// restoring dividers (33 stages for x/sigma, 17 for the weight divide) and two
// registered multiplies. A stall on the output freezes the whole pipeline.
// Write configuration only while the pipeline is empty.
module robust_regression_weight
    import rrw_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [SIGMA_W-1:0] i_cfg_wdata,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [X_W-1:0]     s_axis_tdata,   // [31:0] residual
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [23:0]             m_axis_tdata,   // [16:0] weight, rest zero
    output logic                    m_axis_tuser    // [0] scaled_saturated
);
    t_mode                r_mode;
    logic [K_W-1:0]       r_k;
    logic [SIGMA_W-1:0]   r_sigma;

    logic                 n_adv;
    logic                 n_neg;
    logic [MAGX_W-1:0]    n_mag_x;
    t_ctl                 n_ctl;
    t_ctl                 w_ctl1, w_ctl2, w_ctl3;
    logic [MAGX_W-1:0]    w_mag_u;
    logic                 w_inside;
    logic [W_W-1:0]       w_q, w_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_HUBER;
            r_k     <= K_W'(88146);
            r_sigma <= SIGMA_W'(65536);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODE:  r_mode  <= t_mode'(i_cfg_wdata[0]);
                REG_K:     r_k     <= i_cfg_wdata[K_W-1:0];
                REG_SIGMA: r_sigma <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign n_adv         = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = n_adv;

    always_comb begin
        n_neg       = s_axis_tdata[X_W-1];
        n_mag_x     = n_neg ? (~s_axis_tdata + 1'b1) : s_axis_tdata;
        n_ctl.valid = s_axis_tvalid;
        n_ctl.mode  = r_mode;
        n_ctl.sat   = 1'b0;
        // zero k acts as one LSB
        n_ctl.k     = (r_k == '0) ? K_W'(1) : r_k;
    end

    rrw_scale_div u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (n_adv),
        .i_ctl   (n_ctl),
        .i_neg   (n_neg),
        .i_mag_x (n_mag_x),
        .i_sigma ((r_sigma == '0) ? SIGMA_W'(1) : r_sigma),
        .o_ctl   (w_ctl1),
        .o_mag_u (w_mag_u)
    );

    rrw_weight_div u_wdiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (n_adv),
        .i_ctl    (w_ctl1),
        .i_mag_u  (w_mag_u),
        .o_ctl    (w_ctl2),
        .o_inside (w_inside),
        .o_q      (w_q)
    );

    rrw_shape u_shape (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (n_adv),
        .i_ctl    (w_ctl2),
        .i_inside (w_inside),
        .i_q      (w_q),
        .o_ctl    (w_ctl3),
        .o_weight (w_weight)
    );

    assign m_axis_tvalid = w_ctl3.valid;
    assign m_axis_tdata  = {{(24-W_W){1'b0}}, w_weight};
    assign m_axis_tuser  = w_ctl3.sat;
endmodule
`default_nettype wire

>>> verif/tb_robust_regression_weight.sv
`timescale 1ns / 1ps
module tb_robust_regression_weight;
    import rrw_pkg::*;

    localparam int LATENCY = 56;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [SIGMA_W-1:0] i_cfg_wdata;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [X_W-1:0]     s_axis_tdata;   // [31:0] residual
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [23:0]        m_axis_tdata;   // [16:0] weight, rest zero
    logic               m_axis_tuser;   // [0] scaled_saturated

    typedef struct packed {
        logic [W_W-1:0] weight;
        logic           sat;
    } t_weight_res;

    robust_regression_weight i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // shadow copy of the block's registers
    t_mode          cur_mode;
    logic [K_W-1:0] cur_k;
    logic [SIGMA_W-1:0] cur_sigma;

    t_weight_res pending_weights[$];
    int  error_count;
    bit  idle_enable;
    int  hold_off;

    function automatic t_weight_res calc_weight(logic [X_W-1:0] resid);
        logic [63:0]  mag_x;
        logic [63:0]  sig;
        logic [63:0]  kk;
        logic [63:0]  lim;
        logic [63:0]  mag_u;
        logic [63:0]  a;
        logic [63:0]  b;
        logic [63:0]  w;
        t_weight_res  r;
        mag_x = resid[X_W-1] ? ((64'h1_0000_0000 - {32'd0, resid}) & 64'h1_FFFF_FFFF)
                             : {32'd0, resid};
        sig   = (cur_sigma == 0) ? 64'd1 : {33'd0, cur_sigma};
        kk    = (cur_k == 0) ? 64'd1 : {40'd0, cur_k};
        lim   = resid[X_W-1] ? 64'h8000_0000 : 64'h7FFF_FFFF;
        mag_u = (mag_x << FRAC_BITS) / sig;
        r.sat = 1'b0;
        if (mag_u > lim) begin
            mag_u = lim;
            r.sat = 1'b1;
        end
        if (cur_mode == MODE_BISQUARE) begin
            if (mag_u > kk) begin
                w = 0;
            end else begin
                a = (mag_u << FRAC_BITS) / kk;
                b = (64'd1 << FRAC_BITS) - ((a * a) >> FRAC_BITS);
                w = (b * b) >> FRAC_BITS;
            end
        end else begin
            w = (mag_u <= kk) ? (64'd1 << FRAC_BITS) : ((kk << FRAC_BITS) / mag_u);
        end
        r.weight = w[W_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint exp_val);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, exp_val, $realtime);
        error_count++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("Test completed with failures");
        $finish;
    end

    // receiver: random stall, plus one long hold-off
    initial begin
        m_axis_tready = 1'b0;
        hold_off = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                hold_off--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(idle_enable && ($urandom_range(99) < 12));
            end
        end
    end

    // check each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_weight_res e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_weights.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[W_W-1:0], -1);
            end else begin
                e = pending_weights.pop_front();
                if (m_axis_tdata[W_W-1:0] !== e.weight)
                    report_mismatch("weight", m_axis_tdata[W_W-1:0], e.weight);
                if (m_axis_tuser !== e.sat)
                    report_mismatch("scaled_saturated", m_axis_tuser, e.sat);
                if (m_axis_tdata[23:W_W] !== '0)
                    report_mismatch("tdata pad", m_axis_tdata[23:W_W], 0);
            end
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [SIGMA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_MODE:  cur_mode  = t_mode'(val[0]);
            REG_K:     cur_k     = val[K_W-1:0];
            REG_SIGMA: cur_sigma = val;
            default: ;
        endcase
    endtask

    // Send one residual; expectation is queued at the accepting edge.
    // An expectation typed in the table is checked against the predictor too.
    task automatic send_residual(logic [X_W-1:0] resid, bit has_exp, t_weight_res exp_r);
        t_weight_res p;
        while (idle_enable && ($urandom_range(99) < 12)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= resid;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        p = calc_weight(resid);
        if (has_exp && p !== exp_r)
            report_mismatch("table row vs predictor", p, exp_r);
        pending_weights.push_back(has_exp ? exp_r : p);
    endtask

    task automatic drain();
        int guard;
        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (pending_weights.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    typedef struct {
        logic [X_W-1:0] resid;
        bit             has_exp;
        t_weight_res    exp_r;
    } t_stim_row;

    t_stim_row dir_rows[$];

    function automatic logic [X_W-1:0] rand_resid();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0: return $urandom();
            1: return {{16{1'b0}}, 16'($urandom())};
            2: return -{{16{1'b0}}, 16'($urandom())};
            3: return 32'($urandom_range(200000)) - 100000;
            4: return {$urandom_range(1) ? 1'b1 : 1'b0, 31'($urandom())};
            default: return 32'($signed(cur_k) * $signed($urandom_range(0, 300)) / 100)
                           * ($urandom_range(1) ? 1 : -1);
        endcase
    endfunction

    initial begin
        t_stim_row    row;
        logic [SIGMA_W-1:0] sig_set[6];
        logic [K_W-1:0]     k_set[6];
        int n;
        error_count   = 0;
        idle_enable   = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_MODE;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cur_mode      = MODE_HUBER;
        cur_k         = 24'd88146;
        cur_sigma     = 31'd65536;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows under reset settings (k ~ 1.345, sigma 1.0, Huber)
        dir_rows = '{
            '{32'h0000_0000, 1, '{17'h10000, 1'b0}},
            '{32'h0001_0000, 1, '{17'h10000, 1'b0}},
            '{32'hFFFF_0000, 1, '{17'h10000, 1'b0}},
            '{32'h0001_5852, 1, '{17'h10000, 1'b0}},
            '{32'h0001_5853, 0, '{17'h0, 1'b0}},
            '{32'h0004_0000, 0, '{17'h0, 1'b0}},
            '{32'h7FFF_FFFF, 0, '{17'h0, 1'b0}},
            '{32'h8000_0000, 0, '{17'h0, 1'b0}},
            '{32'hFFFF_FFFF, 1, '{17'h10000, 1'b0}}
        };
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_residual(row.resid, row.has_exp, row.exp_r);
        end
        drain();

        // sigma at its smallest: large residuals saturate, small ones do not; zero sigma acts as one LSB
        write_reg(REG_SIGMA, SIGMA_W'(1));
        send_residual(32'h0000_0001, 0, '0);
        send_residual(32'h8000_0000, 0, '0);
        send_residual(32'h7FFF_FFFF, 0, '0);
        send_residual(32'h0000_0000, 1, '{17'h10000, 1'b0});
        drain();
        write_reg(REG_SIGMA, SIGMA_W'(0));
        write_reg(REG_MODE, SIGMA_W'(1));
        send_residual(32'h8000_0000, 1, '{17'h0, 1'b1});
        send_residual(32'h0000_0000, 1, '{17'h10000, 1'b0});
        drain();
        // bisquare with sigma max and k extremes, zero k acting as one LSB
        write_reg(REG_SIGMA, 31'h7FFF_FFFF);
        write_reg(REG_K, SIGMA_W'(24'hFF_FFFF));
        send_residual(32'h7FFF_FFFF, 0, '0);
        send_residual(32'h8000_0000, 0, '0);
        send_residual(32'h0001_0000, 0, '0);
        drain();
        write_reg(REG_K, SIGMA_W'(0));
        write_reg(REG_SIGMA, SIGMA_W'(65536));
        send_residual(32'h0000_0001, 1, '{17'h0, 1'b0});
        send_residual(32'h0000_0000, 1, '{17'h10000, 1'b0});
        send_residual(32'h0000_8000, 0, '0);
        drain();

        // random phases across settings
        sig_set = '{31'd1, 31'd65536, 31'd3000, 31'h7FFF_FFFF, 31'd700000, 31'd0};
        k_set   = '{24'd1, 24'd88146, 24'd307200, 24'hFF_FFFF, 24'd20000, 24'd0};
        idle_enable = 1;
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(REG_MODE, SIGMA_W'(ph[0]));
            write_reg(REG_SIGMA, (ph % 3 == 2) ? 31'($urandom()) : sig_set[ph % 6]);
            write_reg(REG_K, SIGMA_W'((ph % 4 == 3) ? 24'($urandom()) : k_set[(ph / 2) % 6]));
            idle_enable = (ph != 4);
            n = 100;
            for (int i = 0; i < n; i++) begin
                if (ph == 6 && i == 10) hold_off = 300;
                send_residual(rand_resid(), 0, '0);
            end
            drain();
        end

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/rrw_pkg.sv
rtl/core/rrw_scale_div.sv
rtl/core/rrw_weight_div.sv
rtl/core/rrw_shape.sv
rtl/core/robust_regression_weight.sv
verif/tb_robust_regression_weight.sv
